/* design/rgb_shared_exponent_encoder_assert.svh */
// Assertion macros for the shared-exponent encoder.
`ifndef RGB_SHARED_EXPONENT_ENCODER_ASSERT_SVH
`define RGB_SHARED_EXPONENT_ENCODER_ASSERT_SVH
// Clocked assertion, disabled while reset is active.
`define RSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rse check failed");
// Clocked assertion that is checked through reset as well.
`define RSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rse check failed");
`endif

/* design/rse_pkg.sv */
// Constants for the shared-exponent encoder.
package rse_pkg;
  localparam int unsigned WordW   = 32;
  localparam int unsigned MantW   = 9;
  localparam int unsigned ExpW    = 5;
  localparam logic [MantW-1:0] MantMax = 9'd511;
  localparam logic [30:0] InfAbs  = 31'h7F80_0000;
  localparam logic signed [5:0] ExpMin = -6'sd15;
  localparam logic signed [5:0] ExpMax = 6'sd15;
  localparam logic signed [5:0] ExpBias = 6'sd15;
endpackage

/* design/rgb_shared_exponent_encoder.sv */
// Top level: three float channels in, one shared-exponent word out.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o carry red_bits_i, green_bits_i and
//   blue_bits_i, each an IEEE single-precision bit pattern.
//   Output channel: out_valid_o / out_ready_i carry packed_word_o with the
//   biased exponent in 31:27, blue in 26:18, green in 17:9, red in 8:0.
//   An accepted item passes the input, exponent and result registers in turn.
//   Throughput: one item per cycle when not stalled; three register stages
//   (input, exponent, result) move together, so a full pipe holds three items.
//   When the receiver stalls with the result register full, all stages hold
//   and in_ready_o drops; bubbles in the earlier stages are not squeezed out.
//   Reset clears the stage valid bits; the pipe comes up empty and ready.
//   Negative and NaN channels give mantissa 0, +inf gives 511, and the
//   exponent is clamped to -15..15 (0 for an all-zero or all-NaN item).
`include "rgb_shared_exponent_encoder_assert.svh"
module rgb_shared_exponent_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rse_pkg::WordW-1:0] red_bits_i,
  input  logic [rse_pkg::WordW-1:0] green_bits_i,
  input  logic [rse_pkg::WordW-1:0] blue_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rse_pkg::WordW-1:0] packed_word_o
);
  import rse_pkg::*;

  // Mantissa of one channel for a given shared exponent.
  function automatic logic [MantW-1:0] chan_mant(input logic [31:0] x,
                                                 input logic signed [5:0] e);
    logic [7:0]         biased;
    logic [23:0]        m;
    logic signed [9:0]  k;
    logic signed [9:0]  s;
    logic [9:0]         sh;
    logic [32:0]        prod;
    logic [32:0]        shifted;
    logic [MantW-1:0]   res;
    biased  = x[30:23];
    m       = (biased == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    k       = (biased == 8'd0) ? -10'sd149 : ($signed({2'b00, biased}) - 10'sd150);
    s       = k - 10'(e);
    sh      = 10'(-s);
    prod    = ({9'd0, m} << 9) - {9'd0, m};
    shifted = prod >> sh[5:0];
    res     = '0;
    if (x[31] || (x[30:0] > InfAbs) || (m == 24'd0)) begin
      res = '0;
    end else if (x[30:0] == InfAbs || s >= 10'sd0) begin
      res = MantMax;
    end else if (sh >= 10'd33) begin
      res = '0;
    end else if (shifted > 33'(MantMax)) begin
      res = MantMax;
    end else begin
      res = shifted[MantW-1:0];
    end
    return res;
  endfunction

  logic        adv;
  logic        a_vld_q, b_vld_q, o_vld_q;
  logic [31:0] a_r_q, a_g_q, a_b_q;
  logic [31:0] b_r_q, b_g_q, b_b_q;
  logic signed [5:0] b_e_q;
  logic [31:0] o_word_q;

  // Exponent search signals
  logic [30:0] abs_r, abs_g, abs_b, best_rg, best;
  logic signed [5:0] e_d;
  logic signed [9:0] e_raw;
  logic [31:0] word_d;

  assign adv        = !o_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Largest non-NaN magnitude and its clamped floor(log2)
  always_comb begin
    abs_r   = (a_r_q[30:0] > InfAbs) ? 31'd0 : a_r_q[30:0];
    abs_g   = (a_g_q[30:0] > InfAbs) ? 31'd0 : a_g_q[30:0];
    abs_b   = (a_b_q[30:0] > InfAbs) ? 31'd0 : a_b_q[30:0];
    best_rg = (abs_g > abs_r) ? abs_g : abs_r;
    best    = (abs_b > best_rg) ? abs_b : best_rg;
    e_raw   = $signed({2'b00, best[30:23]}) - 10'sd127;
    if (best == 31'd0) begin
      e_d = 6'sd0;
    end else if (best[30:23] == 8'd0 || e_raw < -10'sd15) begin
      e_d = ExpMin;
    end else if (e_raw > 10'sd15) begin
      e_d = ExpMax;
    end else begin
      e_d = e_raw[5:0];
    end
  end

  // Pack the result word
  always_comb begin
    word_d = {5'(b_e_q + ExpBias), chan_mant(b_b_q, b_e_q),
              chan_mant(b_g_q, b_e_q), chan_mant(b_r_q, b_e_q)};
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      o_vld_q <= b_vld_q;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_r_q    <= red_bits_i;
      a_g_q    <= green_bits_i;
      a_b_q    <= blue_bits_i;
      b_r_q    <= a_r_q;
      b_g_q    <= a_g_q;
      b_b_q    <= a_b_q;
      b_e_q    <= e_d;
      o_word_q <= word_d;
    end
  end

  assign out_valid_o   = o_vld_q;
  assign packed_word_o = o_word_q;

  `RSE_ASSERT(a_exp_range, clk_i, rst_ni, o_vld_q |-> (o_word_q[31:27] <= 5'd30))
  `RSE_ASSERT(a_in_to_a, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> a_vld_q)
  `RSE_ASSERT(a_b_to_o, clk_i, rst_ni, (b_vld_q && adv) |=> o_vld_q)
  `RSE_ASSERT(a_hold, clk_i, rst_ni, (o_vld_q && !out_ready_i) |=> $stable(b_e_q))
endmodule
